// ----- rtl/sadm_pkg.sv -----
// Package for the signed add/sub/mul/div unit.
// Holds operation codes, the default data width and the per-stage control bundle.
// No dependencies.
package sadm_pkg;

    localparam int DATA_WIDTH = 32;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_ADD = 2'd0;
    localparam mode_t MODE_SUB = 2'd1;
    localparam mode_t MODE_MUL = 2'd2;
    localparam mode_t MODE_DIV = 2'd3;

    typedef struct packed {
        mode_t mode;
        logic  neg;
        logic  zero;
    } ctrl_t;

endpackage

// ----- rtl/sadm_req_if.sv -----
// Request channel of the signed add/sub/mul/div unit: mode and two operands.
// Depends on sadm_pkg.
interface sadm_req_if #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH
);
    logic                    valid;
    logic                    ready;
    sadm_pkg::mode_t         mode;
    logic signed [WIDTH-1:0] operand_a;
    logic signed [WIDTH-1:0] operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    output ready);
endinterface

// ----- rtl/sadm_rsp_if.sv -----
// Response channel of the signed add/sub/mul/div unit: one signed result.
// Depends on sadm_pkg.
interface sadm_rsp_if #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ----- rtl/sadm_prep.sv -----
// Entry stage: add/sub results, operand magnitudes and sign flags for divide.
// Depends on sadm_pkg.
module sadm_prep #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sadm_pkg::mode_t      in_mode,
    input  logic [WIDTH-1:0]     in_a,
    input  logic [WIDTH-1:0]     in_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sadm_pkg::ctrl_t      out_ctrl,
    output logic [WIDTH-1:0]     out_acc,
    output logic [WIDTH-1:0]     out_opa,
    output logic [WIDTH-1:0]     out_opb,
    output logic [WIDTH-1:0]     out_quo
);

    logic             valid_reg;
    sadm_pkg::ctrl_t  ctrl_reg, ctrl_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] opa_reg, opa_next;
    logic [WIDTH-1:0] opb_reg, opb_next;
    logic [WIDTH-1:0] mag_a, mag_b;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign mag_a = in_a[WIDTH-1] ? (~in_a + WIDTH'(1)) : in_a;
    assign mag_b = in_b[WIDTH-1] ? (~in_b + WIDTH'(1)) : in_b;

    always_comb
    begin
        ctrl_next.mode = in_mode;
        ctrl_next.neg  = in_a[WIDTH-1] ^ in_b[WIDTH-1];
        ctrl_next.zero = (in_b == '0);
        acc_next       = '0;
        opa_next       = in_a;
        opb_next       = in_b;
        case (in_mode)
            sadm_pkg::MODE_ADD: acc_next = in_a + in_b;
            sadm_pkg::MODE_SUB: acc_next = in_a - in_b;
            sadm_pkg::MODE_DIV:
            begin
                opa_next = mag_a;
                opb_next = mag_b;
            end
            default: acc_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= ctrl_next;
            acc_reg  <= acc_next;
            opa_reg  <= opa_next;
            opb_reg  <= opb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_acc   = acc_reg;
    assign out_opa   = opa_reg;
    assign out_opb   = opb_reg;
    assign out_quo   = '0;

endmodule

// ----- rtl/sadm_cell.sv -----
// One bit step of the chain: a shift-add multiply step or a restoring divide step.
// Depends on sadm_pkg.
module sadm_cell #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH,
    parameter int IDX   = WIDTH - 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sadm_pkg::ctrl_t      in_ctrl,
    input  logic [WIDTH-1:0]     in_acc,
    input  logic [WIDTH-1:0]     in_opa,
    input  logic [WIDTH-1:0]     in_opb,
    input  logic [WIDTH-1:0]     in_quo,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sadm_pkg::ctrl_t      out_ctrl,
    output logic [WIDTH-1:0]     out_acc,
    output logic [WIDTH-1:0]     out_opa,
    output logic [WIDTH-1:0]     out_opb,
    output logic [WIDTH-1:0]     out_quo
);

    logic             valid_reg;
    sadm_pkg::ctrl_t  ctrl_reg;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] opa_reg;
    logic [WIDTH-1:0] opb_reg;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH:0]   rem_wide;
    logic [WIDTH:0]   diff;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // partial remainder keeps the bit shifted out at the top
    assign rem_wide = {in_acc, in_opa[IDX]};
    assign diff     = rem_wide - {1'b0, in_opb};

    always_comb
    begin
        acc_next = in_acc;
        quo_next = in_quo;
        case (in_ctrl.mode)
            sadm_pkg::MODE_MUL:
            begin
                acc_next = {in_acc[WIDTH-2:0], 1'b0} + (in_opb[IDX] ? in_opa : '0);
            end
            sadm_pkg::MODE_DIV:
            begin
                if (!diff[WIDTH])
                begin
                    acc_next = diff[WIDTH-1:0];
                    quo_next = {in_quo[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_wide[WIDTH-1:0];
                    quo_next = {in_quo[WIDTH-2:0], 1'b0};
                end
            end
            default:
            begin
                acc_next = in_acc;
                quo_next = in_quo;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= in_ctrl;
            acc_reg  <= acc_next;
            opa_reg  <= in_opa;
            opb_reg  <= in_opb;
            quo_reg  <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_acc   = acc_reg;
    assign out_opa   = opa_reg;
    assign out_opb   = opb_reg;
    assign out_quo   = quo_reg;

endmodule

// ----- rtl/sadm_fin.sv -----
// Exit stage: quotient sign fix, zero-divisor result and the output register.
// Depends on sadm_pkg.
module sadm_fin #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sadm_pkg::ctrl_t      in_ctrl,
    input  logic [WIDTH-1:0]     in_acc,
    input  logic [WIDTH-1:0]     in_quo,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WIDTH-1:0]     out_result
);

    logic             valid_reg;
    logic [WIDTH-1:0] result_reg, result_next;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        result_next = in_acc;
        if (in_ctrl.mode == sadm_pkg::MODE_DIV)
        begin
            if (in_ctrl.zero)
            begin
                result_next = '0;
            end
            else if (in_ctrl.neg)
            begin
                result_next = ~in_quo + WIDTH'(1);
            end
            else
            begin
                result_next = in_quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- rtl/signed_int_add_sub_mul_div_unit.sv -----
// Signed integer add / subtract / multiply / divide unit, top level.
// Depends on sadm_pkg, sadm_req_if, sadm_rsp_if, sadm_prep, sadm_cell, sadm_fin.
//
// Usage:
//   req  : valid/ready channel carrying mode (0 add, 1 sub, 2 mul, 3 div),
//          operand_a and operand_b, two's complement WIDTH bits.
//   rsp  : valid/ready channel carrying one WIDTH-bit result per transaction.
//   Add, sub and mul wrap; mul returns the low word. Divide truncates toward
//   zero, a zero divisor returns 0, INT_MIN / -1 returns INT_MIN.
//   Every mode passes through the same stages: one entry stage, WIDTH bit
//   cells (one multiply or divide bit each), one output register.
//   Throughput is one transaction per cycle while rsp is not stalled; every stage has its own valid
//   and register, so a new transaction enters while older ones are in flight.
//   When rsp is stalled, the held result stays put and stages behind it keep
//   filling any empty slots; req.ready drops only once the chain is full.
//   Reset clears all stage valids; no transaction is in flight afterwards.
module signed_int_add_sub_mul_div_unit #(
    parameter int WIDTH = sadm_pkg::DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sadm_req_if.sink   req,
    sadm_rsp_if.source rsp
);

    logic             stg_valid [WIDTH+1];
    logic             stg_ready [WIDTH+1];
    sadm_pkg::ctrl_t  stg_ctrl  [WIDTH+1];
    logic [WIDTH-1:0] stg_acc   [WIDTH+1];
    logic [WIDTH-1:0] stg_opa   [WIDTH+1];
    logic [WIDTH-1:0] stg_opb   [WIDTH+1];
    logic [WIDTH-1:0] stg_quo   [WIDTH+1];
    logic [WIDTH-1:0] result_u;

    sadm_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_mode   (req.mode),
        .in_a      (WIDTH'(unsigned'(req.operand_a))),
        .in_b      (WIDTH'(unsigned'(req.operand_b))),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_ctrl  (stg_ctrl[0]),
        .out_acc   (stg_acc[0]),
        .out_opa   (stg_opa[0]),
        .out_opb   (stg_opb[0]),
        .out_quo   (stg_quo[0])
    );

    for (genvar k = 0; k < WIDTH; k++)
    begin : g_cell
        sadm_cell #(
            .WIDTH (WIDTH),
            .IDX   (WIDTH - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_ctrl   (stg_ctrl[k]),
            .in_acc    (stg_acc[k]),
            .in_opa    (stg_opa[k]),
            .in_opb    (stg_opb[k]),
            .in_quo    (stg_quo[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_ctrl  (stg_ctrl[k+1]),
            .out_acc   (stg_acc[k+1]),
            .out_opa   (stg_opa[k+1]),
            .out_opb   (stg_opb[k+1]),
            .out_quo   (stg_quo[k+1])
        );
    end

    sadm_fin #(
        .WIDTH (WIDTH)
    ) u_fin (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[WIDTH]),
        .in_ready   (stg_ready[WIDTH]),
        .in_ctrl    (stg_ctrl[WIDTH]),
        .in_acc     (stg_acc[WIDTH]),
        .in_quo     (stg_quo[WIDTH]),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_result (result_u)
    );

    assign rsp.result = signed'(result_u);

endmodule

// ----- bench/tb.sv -----
// Testbench for signed_int_add_sub_mul_div_unit: directed corners, random traffic,
// receiver back-pressure and a sender drain pause, each checked against a local predictor.
// Depends on sadm_pkg, sadm_req_if, sadm_rsp_if and the unit itself.
module tb;

    localparam int W = sadm_pkg::DATA_WIDTH;
    localparam logic [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] INT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = W + 8;

    logic clk = 1'b0;
    logic rst_n;

    sadm_req_if #(.WIDTH(W)) req ();
    sadm_rsp_if #(.WIDTH(W)) rsp ();

    signed_int_add_sub_mul_div_unit #(.WIDTH(W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    logic [W-1:0] expected_results[$];
    logic [W-1:0] want_result;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           rsp_hold_cycles = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;

    function automatic logic [W-1:0] predict_result(sadm_pkg::mode_t m, logic [W-1:0] a,
                                                    logic [W-1:0] b);
        logic [W-1:0] prod;
        logic [W-1:0] mag_a;
        logic [W-1:0] mag_b;
        logic [W-1:0] quo;
        logic [W:0]   rem;
        prod = '0;
        quo  = '0;
        rem  = '0;
        case (m)
            sadm_pkg::MODE_ADD: return a + b;
            sadm_pkg::MODE_SUB: return a - b;
            sadm_pkg::MODE_MUL:
            begin
                for (int i = 0; i < W; i++)
                    if (b[i])
                        prod = prod + (a << i);
                return prod;
            end
            default:
            begin
                if (b == '0)
                    return '0;
                mag_a = a[W-1] ? -a : a;
                mag_b = b[W-1] ? -b : b;
                for (int i = W - 1; i >= 0; i--)
                begin
                    rem = {rem[W-1:0], mag_a[i]};
                    if (rem >= {1'b0, mag_b})
                    begin
                        rem    = rem - {1'b0, mag_b};
                        quo[i] = 1'b1;
                    end
                end
                return (a[W-1] != b[W-1]) ? -quo : quo;
            end
        endcase
    endfunction

    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        case ($urandom_range(7))
            0: case ($urandom_range(4))
                   0: v = INT_MIN;
                   1: v = INT_MAX;
                   2: v = '0;
                   3: v = 1;
                   default: v = ALL_ONES;
               endcase
            1, 2: v = W'($urandom_range(200)) - 100;
            3, 4:
            begin
                v = $urandom >> $urandom_range(W - 1);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_op(input sadm_pkg::mode_t m, input logic [W-1:0] a,
                           input logic [W-1:0] b);
        if (tx_idle_en)
            while ($urandom_range(99) < 23)
            begin
                req.valid <= 1'b0;
                @(negedge clk);
            end
        req.valid     <= 1'b1;
        req.mode      <= m;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_results.push_back(predict_result(m, a, b));
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_op(sadm_pkg::mode_t'($urandom_range(3)), pick_operand(), pick_operand());
    endtask

    task automatic pause_tx();
        req.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_op(sadm_pkg::MODE_ADD, INT_MAX, 1);
        send_op(sadm_pkg::MODE_ADD, INT_MIN, ALL_ONES);
        send_op(sadm_pkg::MODE_ADD, '0, '0);
        send_op(sadm_pkg::MODE_ADD, ALL_ONES, ALL_ONES);
        send_op(sadm_pkg::MODE_SUB, INT_MIN, 1);
        send_op(sadm_pkg::MODE_SUB, INT_MAX, ALL_ONES);
        send_op(sadm_pkg::MODE_SUB, '0, INT_MIN);
        send_op(sadm_pkg::MODE_MUL, INT_MAX, INT_MAX);
        send_op(sadm_pkg::MODE_MUL, INT_MIN, ALL_ONES);
        send_op(sadm_pkg::MODE_MUL, ALL_ONES, ALL_ONES);
        send_op(sadm_pkg::MODE_MUL, 32'h0001_0000, 32'h0001_0000);
        send_op(sadm_pkg::MODE_DIV, 7, '0);
        send_op(sadm_pkg::MODE_DIV, INT_MIN, '0);
        send_op(sadm_pkg::MODE_DIV, INT_MIN, ALL_ONES);
        send_op(sadm_pkg::MODE_DIV, INT_MIN, 1);
        send_op(sadm_pkg::MODE_DIV, INT_MIN, INT_MIN);
        send_op(sadm_pkg::MODE_DIV, 5, INT_MIN);
        send_op(sadm_pkg::MODE_DIV, INT_MAX, INT_MIN);
        send_op(sadm_pkg::MODE_DIV, -7, 2);
        send_op(sadm_pkg::MODE_DIV, 7, -2);
        send_op(sadm_pkg::MODE_DIV, INT_MAX, 1);
        send_op(sadm_pkg::MODE_DIV, 100, 7);
        send_op(sadm_pkg::MODE_DIV, INT_MIN, 2);
    endtask

    task automatic test_random_mixed();
        send_random(480);
    endtask

    task automatic test_no_idle();
        pause_tx();
        @(posedge clk);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(negedge clk);
        send_random(200);
        pause_tx();
        @(posedge clk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        @(negedge clk);
    endtask

    // receiver stalls long enough for the chain to fill and drop req.ready
    task automatic test_backpressure();
        pause_tx();
        @(posedge clk);
        tx_idle_en = 1'b0;
        rsp_hold_cycles = 300;
        @(negedge clk);
        send_random(120);
        pause_tx();
        @(posedge clk);
        tx_idle_en = 1'b1;
        @(negedge clk);
    endtask

    task automatic test_drain_pause();
        pause_tx();
        wait_all_results();
        send_random(80);
    endtask

    always @(negedge clk)
    begin
        if (rsp_hold_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold_cycles <= rsp_hold_cycles - 1;
        end
        else
            rsp.ready <= !rx_idle_en || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected transaction: result %h", rsp.result);
                fail_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (rsp.result !== want_result)
                begin
                    if (fail_count < 10)
                        $display("result mismatch: expected %h actual %h",
                                 want_result, rsp.result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.mode      = sadm_pkg::MODE_ADD;
        req.operand_a = '0;
        req.operand_b = '0;
        rsp.ready     = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mixed();
        test_no_idle();
        test_backpressure();
        test_drain_pause();

        pause_tx();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
